@@ hw/rtl/shs_pkg.sv @@
`timescale 1ns / 1ps

package shs_pkg;

  localparam int unsigned BLOCK_WORDS  = 16;
  localparam int unsigned HASH_WORDS   = 8;
  localparam int unsigned ROUNDS       = 64;
  localparam logic [7:0]  PAD_BYTE     = 8'h80;

  localparam logic [31:0] ROUND_K [ROUNDS] = '{
    32'h428A2F98, 32'h71374491, 32'hB5C0FBCF, 32'hE9B5DBA5,
    32'h3956C25B, 32'h59F111F1, 32'h923F82A4, 32'hAB1C5ED5,
    32'hD807AA98, 32'h12835B01, 32'h243185BE, 32'h550C7DC3,
    32'h72BE5D74, 32'h80DEB1FE, 32'h9BDC06A7, 32'hC19BF174,
    32'hE49B69C1, 32'hEFBE4786, 32'h0FC19DC6, 32'h240CA1CC,
    32'h2DE92C6F, 32'h4A7484AA, 32'h5CB0A9DC, 32'h76F988DA,
    32'h983E5152, 32'hA831C66D, 32'hB00327C8, 32'hBF597FC7,
    32'hC6E00BF3, 32'hD5A79147, 32'h06CA6351, 32'h14292967,
    32'h27B70A85, 32'h2E1B2138, 32'h4D2C6DFC, 32'h53380D13,
    32'h650A7354, 32'h766A0ABB, 32'h81C2C92E, 32'h92722C85,
    32'hA2BFE8A1, 32'hA81A664B, 32'hC24B8B70, 32'hC76C51A3,
    32'hD192E819, 32'hD6990624, 32'hF40E3585, 32'h106AA070,
    32'h19A4C116, 32'h1E376C08, 32'h2748774C, 32'h34B0BCB5,
    32'h391C0CB3, 32'h4ED8AA4A, 32'h5B9CCA4F, 32'h682E6FF3,
    32'h748F82EE, 32'h78A5636F, 32'h84C87814, 32'h8CC70208,
    32'h90BEFFFA, 32'hA4506CEB, 32'hBEF9A3F7, 32'hC67178F2
  };

  localparam logic [31:0] HASH_INIT [HASH_WORDS] = '{
    32'h6A09E667, 32'hBB67AE85, 32'h3C6EF372, 32'hA54FF53A,
    32'h510E527F, 32'h9B05688C, 32'h1F83D9AB, 32'h5BE0CD19
  };

  typedef struct packed {
    logic [7:0] msg_byte;
    logic       byte_present;
    logic       end_of_message;
  } msg_t;

  typedef struct packed {
    logic [31:0] digest_word;
    logic [2:0]  word_number;
    logic        final_word;
  } digest_t;

  typedef struct packed {
    logic byte_shift;
    logic word_shift;
  } sched_ctrl_t;

  typedef struct packed {
    logic       hash_init;
    logic       vars_load;
    logic       round_step;
    logic       hash_add;
    logic [5:0] round_idx;
  } round_ctrl_t;

  function automatic logic [31:0] ror(input logic [31:0] x, input int unsigned n);
    return (x >> n) | (x << (32 - n));
  endfunction

  function automatic logic [31:0] small_sigma0(input logic [31:0] x);
    return ror(x, 7) ^ ror(x, 18) ^ (x >> 3);
  endfunction

  function automatic logic [31:0] small_sigma1(input logic [31:0] x);
    return ror(x, 17) ^ ror(x, 19) ^ (x >> 10);
  endfunction

  function automatic logic [31:0] big_sigma0(input logic [31:0] x);
    return ror(x, 2) ^ ror(x, 13) ^ ror(x, 22);
  endfunction

  function automatic logic [31:0] big_sigma1(input logic [31:0] x);
    return ror(x, 6) ^ ror(x, 11) ^ ror(x, 25);
  endfunction

endpackage

@@ hw/rtl/sha256_stream_hasher.sv @@
`timescale 1ns / 1ps
// A request with a message byte is taken while the sequencer is idle; a byte that
// completes a 64-byte block then runs 64 rounds of the shared round unit and the
// hash update before the next byte is taken. An end request adds the pad bytes
// plus one or two such compressions, then the eight digest words leave at one per
// cycle as the sink takes them. Reset returns the sequencer to idle, loads the
// initial hash values and clears the counters.

module sha256_stream_hasher
  import shs_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    msg_valid,
  output logic    msg_ready,
  input  msg_t    msg,
  output logic    digest_valid,
  input  logic    digest_ready,
  output digest_t digest
);

  typedef enum logic [4:0] {
    ST_IDLE = 5'b00001,
    ST_COMP = 5'b00010,
    ST_ADD  = 5'b00100,
    ST_PAD  = 5'b01000,
    ST_OUT  = 5'b10000
  } state_t;

  state_t      state;
  state_t      state_next;
  logic [5:0]  fill;
  logic [60:0] byte_count;
  logic [5:0]  round_idx;
  logic [2:0]  word_idx;
  // Padding bookkeeping: the 0x80 byte has gone in, the length field has
  // started, the running compression is the last one of the message, and a
  // compression that ends a data block must be followed by padding.
  logic        pad_started;
  logic        len_phase;
  logic        final_blk;
  logic        resume_pad;

  logic        msg_take;
  logic        digest_take;
  logic        len_sel;
  logic [63:0] bit_len;
  logic [7:0]  len_byte;
  logic [7:0]  pad_byte;
  logic [7:0]  shift_byte;

  sched_ctrl_t sched_ctrl;
  round_ctrl_t round_ctrl;
  logic [31:0] sched_word;
  logic [31:0] hash [HASH_WORDS];

  assign msg_ready    = (state == ST_IDLE);
  assign digest_valid = (state == ST_OUT);
  assign msg_take     = msg_valid && msg_ready;
  assign digest_take  = digest_valid && digest_ready;

  // The length bytes fill the last eight buffer positions, most significant
  // byte first. A 0x80 byte that lands in those positions forces zeros up to
  // the end of the block instead, so the length only starts at position 56.
  assign len_sel  = pad_started && (fill[5:3] == 3'b111) && (fill[2:0] == 3'b000 || len_phase);
  assign bit_len  = {byte_count, 3'b000};
  assign len_byte = 8'(bit_len >> {~fill[2:0], 3'b000});
  assign pad_byte = !pad_started ? PAD_BYTE : (len_sel ? len_byte : 8'h00);

  always_comb begin
    state_next = state;
    sched_ctrl = '0;
    round_ctrl = '0;
    round_ctrl.round_idx = round_idx;
    shift_byte = pad_byte;
    unique case (state)
      ST_IDLE: begin
        shift_byte = msg.msg_byte;
        if (msg_take) begin
          if (msg.byte_present) begin
            sched_ctrl.byte_shift = 1'b1;
            if (&fill) begin
              state_next = ST_COMP;
              round_ctrl.vars_load = 1'b1;
            end else if (msg.end_of_message) begin
              state_next = ST_PAD;
            end
          end else if (msg.end_of_message) begin
            state_next = ST_PAD;
          end
        end
      end
      ST_COMP: begin
        sched_ctrl.word_shift = 1'b1;
        round_ctrl.round_step = 1'b1;
        if (&round_idx) begin
          state_next = ST_ADD;
        end
      end
      ST_ADD: begin
        round_ctrl.hash_add = 1'b1;
        if (final_blk) begin
          state_next = ST_OUT;
        end else if (resume_pad) begin
          state_next = ST_PAD;
        end else begin
          state_next = ST_IDLE;
        end
      end
      ST_PAD: begin
        sched_ctrl.byte_shift = 1'b1;
        if (&fill) begin
          state_next = ST_COMP;
          round_ctrl.vars_load = 1'b1;
        end
      end
      ST_OUT: begin
        if (digest_take && (&word_idx)) begin
          round_ctrl.hash_init = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      fill        <= '0;
      byte_count  <= '0;
      round_idx   <= '0;
      word_idx    <= '0;
      pad_started <= 1'b0;
      len_phase   <= 1'b0;
      final_blk   <= 1'b0;
      resume_pad  <= 1'b0;
    end else begin
      state <= state_next;
      if (sched_ctrl.byte_shift) begin
        fill <= fill + 6'd1;
      end
      if (msg_take && msg.byte_present) begin
        byte_count <= byte_count + 61'd1;
      end
      if (msg_take && (&fill) && msg.byte_present) begin
        resume_pad <= msg.end_of_message;
      end
      if (state == ST_PAD) begin
        pad_started <= 1'b1;
        if (len_sel) begin
          len_phase <= 1'b1;
        end
        if (&fill) begin
          final_blk  <= len_sel;
          resume_pad <= 1'b1;
        end
      end
      if (state == ST_COMP) begin
        round_idx <= round_idx + 6'd1;
      end
      if (digest_take) begin
        word_idx <= word_idx + 3'd1;
        if (&word_idx) begin
          byte_count  <= '0;
          pad_started <= 1'b0;
          len_phase   <= 1'b0;
          final_blk   <= 1'b0;
          resume_pad  <= 1'b0;
        end
      end
    end
  end

  // The digest is read straight from the hash registers, which hold still
  // while the sequencer waits in the output state.
  assign digest.digest_word = hash[word_idx];
  assign digest.word_number = word_idx;
  assign digest.final_word  = &word_idx;

  shs_sched u_sched (
    .clk      (clk),
    .ctrl     (sched_ctrl),
    .byte_in  (shift_byte),
    .word_out (sched_word)
  );

  shs_round u_round (
    .clk        (clk),
    .rst        (rst),
    .ctrl       (round_ctrl),
    .sched_word (sched_word),
    .hash       (hash)
  );

endmodule

@@ hw/rtl/shs_sched.sv @@
`timescale 1ns / 1ps

module shs_sched
  import shs_pkg::*;
(
  input  logic        clk,
  input  sched_ctrl_t ctrl,
  input  logic [7:0]  byte_in,
  output logic [31:0] word_out
);

  // One shift line serves as the block buffer while bytes arrive and as the
  // sliding message schedule window during the rounds.
  logic [31:0] sched [BLOCK_WORDS];
  logic [31:0] word_new;

  assign word_new = small_sigma1(sched[14]) + sched[9] + small_sigma0(sched[1]) + sched[0];
  assign word_out = sched[0];

  always_ff @(posedge clk) begin
    if (ctrl.byte_shift) begin
      for (int i = 0; i < BLOCK_WORDS - 1; i++) begin
        sched[i] <= {sched[i][23:0], sched[i + 1][31:24]};
      end
      sched[BLOCK_WORDS - 1] <= {sched[BLOCK_WORDS - 1][23:0], byte_in};
    end else if (ctrl.word_shift) begin
      for (int i = 0; i < BLOCK_WORDS - 1; i++) begin
        sched[i] <= sched[i + 1];
      end
      sched[BLOCK_WORDS - 1] <= word_new;
    end
  end

endmodule

@@ hw/rtl/shs_round.sv @@
`timescale 1ns / 1ps

module shs_round
  import shs_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  round_ctrl_t ctrl,
  input  logic [31:0] sched_word,
  output logic [31:0] hash [HASH_WORDS]
);

  logic [31:0] v [HASH_WORDS];
  logic [31:0] t1;
  logic [31:0] t2;

  assign t1 = v[7] + big_sigma1(v[4]) + ((v[4] & v[5]) ^ (~v[4] & v[6])) +
              ROUND_K[ctrl.round_idx] + sched_word;
  assign t2 = big_sigma0(v[0]) + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));

  always_ff @(posedge clk) begin
    if (ctrl.vars_load) begin
      v <= hash;
    end else if (ctrl.round_step) begin
      v[7] <= v[6];
      v[6] <= v[5];
      v[5] <= v[4];
      v[4] <= v[3] + t1;
      v[3] <= v[2];
      v[2] <= v[1];
      v[1] <= v[0];
      v[0] <= t1 + t2;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || ctrl.hash_init) begin
      hash <= HASH_INIT;
    end else if (ctrl.hash_add) begin
      for (int k = 0; k < HASH_WORDS; k++) begin
        hash[k] <= hash[k] + v[k];
      end
    end
  end

endmodule
